// ----- sv/crr_pkg.sv -----
// Package: shared types and constants of the circuit receive engine.
package crr_pkg;
  localparam int CIRCUITS_DEF = 32;
  localparam int MAX_MESSAGE_DEF = 8292;
  localparam int PAYLOAD_MAX = 1490;

  localparam logic [1:0] MODE_OPEN = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [3:0] ST_FRAG = 4'd0;
  localparam logic [3:0] ST_DELIV = 4'd1;
  localparam logic [3:0] ST_DUP = 4'd2;
  localparam logic [3:0] ST_NOCL = 4'd3;
  localparam logic [3:0] ST_BAD = 4'd4;
  localparam logic [3:0] ST_SHORT = 4'd5;
  localparam logic [3:0] ST_ORDER = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;
  localparam logic [3:0] ST_OVER = 4'd8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  slot;
    logic [47:0] peer_mac;
    logic        wants_ack;
    logic [23:0] circuit_number;
    logic        hangup_flag;
    logic [7:0]  message_id;
    logic [7:0]  piggy_ack;
    logic signed [15:0] remaining;
    logic [10:0] payload_length;
  } req_t;

  typedef struct packed {
    logic [4:0]  circuit_slot;
    logic [3:0]  status;
    logic [13:0] copy_offset;
    logic [10:0] copy_length;
    logic        deliver;
    logic [13:0] message_length;
    logic        send_ack;
    logic [7:0]  ack_mid;
    logic [7:0]  ack_ack;
    logic        resume_client;
    logic        hangup_now;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    req_t        req;
    logic        hit;
    logic [7:0]  slot_idx;
  } job_t;
endpackage

// ----- sv/crr_if.sv -----
// Interface: valid/ready channel carrying one payload.
interface crr_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/crr_front.sv -----
// Front: accept requests, search the circuit table, queue classified jobs.
module crr_front #(
  parameter int CIRCUITS = crr_pkg::CIRCUITS_DEF,
  parameter int IW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  crr_pkg::req_t in_data,
  input  logic [CIRCUITS-1:0] cv,
  input  logic [CIRCUITS-1:0][23:0] rc,
  input  logic [CIRCUITS-1:0][47:0] pa,
  input  logic busy,
  output logic job_valid,
  input  logic job_ready,
  output crr_pkg::job_t job
);
  // Hold one request per step; busy blocks while the back updates the table.
  logic        full;
  crr_pkg::req_t r;
  logic        hit_c;
  logic [IW-1:0] idx_c;

  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    for (int s = CIRCUITS - 1; s >= 0; s--) begin
      if (cv[s] && rc[s] == r.circuit_number && pa[s] == r.peer_mac) begin
        hit_c = 1'b1;
        idx_c = IW'(s);
      end
    end
    if (r.mode != crr_pkg::MODE_RECV) begin
      hit_c = (int'(r.slot) < CIRCUITS);
      idx_c = IW'(r.slot);
    end
  end

  assign in_ready = !full && !busy;
  assign job_valid = full;
  assign job.req = r;
  assign job.hit = hit_c;
  assign job.slot_idx = 8'(idx_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= (in_data.mode != crr_pkg::MODE_NONE);
    end else if (job_valid && job_ready) begin
      full <= 1'b0;
    end
    if (in_valid && in_ready) r <= in_data;
  end
endmodule

// ----- sv/crr_back.sv -----
// Back: apply one job to the circuit table and register the response.
module crr_back #(
  parameter int CIRCUITS = crr_pkg::CIRCUITS_DEF,
  parameter int MAX_MESSAGE = crr_pkg::MAX_MESSAGE_DEF,
  parameter int IW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  crr_pkg::job_t job,
  output logic busy,
  output logic [CIRCUITS-1:0] cv,
  output logic [CIRCUITS-1:0][23:0] rc,
  output logic [CIRCUITS-1:0][47:0] pa,
  output logic out_valid,
  input  logic out_ready,
  output crr_pkg::rsp_t out_data
);
  logic [CIRCUITS-1:0][17:0] ver;
  logic [CIRCUITS-1:0]       aw;
  logic [CIRCUITS-1:0][7:0]  lr, cm, ls, la;
  logic [CIRCUITS-1:0][16:0] br;
  logic [CIRCUITS-1:0][13:0] bf;

  logic [IW-1:0] s;
  crr_pkg::rsp_t o;
  logic [10:0] len0;
  logic signed [17:0] rem, brn;
  logic [10:0] ln;
  logic [13:0] fill;
  logic [7:0] lsn;
  logic [23:0] rcb;
  logic [23:0] rcn;
  logic take;

  assign s = job.slot_idx[IW-1:0];
  assign take = job_valid && (!out_valid || out_ready);
  assign job_ready = take;
  assign busy = job_valid;

  always_comb begin
    o = '0;
    o.circuit_slot = job.req.slot;
    // Derive the receive circuit number from slot and version on open.
    rcb = 24'(ver[s]) * 24'(CIRCUITS) + 24'(s);
    rcn = {rcb[22:0], 1'b1};
    len0 = (job.req.payload_length > 11'(crr_pkg::PAYLOAD_MAX)) ?
           11'(crr_pkg::PAYLOAD_MAX) : job.req.payload_length;
    rem = 18'(job.req.remaining);
    brn = 18'(signed'(br[s])) - 18'(signed'({1'b0, len0}));
    if (rem >= 0) brn = rem - 18'(signed'({1'b0, len0}));
    ln = len0;
    fill = (rem >= 0) ? 14'd0 : bf[s];
    lsn = ls[s];
    if (job.req.mode == crr_pkg::MODE_RECV) begin
      o.circuit_slot = job.hit ? 5'(s) : 5'd0;
      if (!job.hit) begin
        o.status = crr_pkg::ST_NOCL;
        o.send_ack = 1'b1;
        o.ack_mid = job.req.piggy_ack;
        o.ack_ack = job.req.message_id;
      end else if (rem >= 0 && rem > 18'(MAX_MESSAGE)) begin
        o.status = crr_pkg::ST_OVER;
      end else if (rem < 0 && (cm[s] != job.req.message_id ||
                               -rem != 18'(signed'(br[s])))) begin
        o.status = crr_pkg::ST_BAD;
      end else if (brn < 0 && -brn > 18'(signed'({1'b0, len0}))) begin
        o.status = crr_pkg::ST_SHORT;
      end else begin
        if (brn < 0) ln = 11'(18'(len0) + brn);
        o.copy_offset = fill;
        o.copy_length = ln;
        fill = fill + 14'(ln);
        if (brn > 0) begin
          o.status = crr_pkg::ST_FRAG;
        end else if (8'(lr[s] + 8'd1) != job.req.message_id) begin
          if (lr[s] == job.req.message_id) begin
            o.status = crr_pkg::ST_DUP;
            if (fill != 0) begin
              o.send_ack = 1'b1;
              o.ack_mid = ls[s];
              o.ack_ack = lr[s];
            end
            o.resume_client = (job.req.piggy_ack == ls[s]);
          end else begin
            o.status = crr_pkg::ST_ORDER;
          end
        end else begin
          o.status = crr_pkg::ST_DELIV;
          o.resume_client = (job.req.piggy_ack == ls[s]);
          if (fill != 0) begin
            o.deliver = 1'b1;
            o.message_length = fill;
          end
          if (job.req.hangup_flag) begin
            lsn = ls[s] + 8'd1;
            o.resume_client = 1'b0;
            o.hangup_now = 1'b1;
          end
          if (aw[s]) begin
            o.send_ack = 1'b1;
            o.ack_mid = lsn;
            o.ack_ack = job.req.message_id;
          end
        end
      end
    end else if (!job.hit) begin
      o.status = crr_pkg::ST_NOCL;
    end else if (job.req.mode == crr_pkg::MODE_SEND && !cv[s]) begin
      o.status = crr_pkg::ST_NOCL;
    end else begin
      o.status = crr_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cv <= '0;
      ver <= '0;
    end else begin
      out_valid <= take || (out_valid && !out_ready);
      if (take) begin
        out_data <= o;
        if (job.hit) begin
          unique case (job.req.mode)
            crr_pkg::MODE_OPEN: begin
              cv[s] <= 1'b1;
              rc[s] <= rcn;
              ver[s] <= ver[s] + 18'd1;
              pa[s] <= job.req.peer_mac;
              aw[s] <= job.req.wants_ack;
              lr[s] <= '0; cm[s] <= '0; br[s] <= '0; bf[s] <= '0;
              ls[s] <= '0; la[s] <= '0;
            end
            crr_pkg::MODE_SEND: if (cv[s]) ls[s] <= ls[s] + 8'd1;
            default: begin
              if (rem >= 0) cm[s] <= job.req.message_id;
              case (o.status) inside
                crr_pkg::ST_OVER, crr_pkg::ST_ORDER: begin
                  br[s] <= '0; bf[s] <= '0;
                end
                crr_pkg::ST_BAD: bf[s] <= '0;
                crr_pkg::ST_SHORT, crr_pkg::ST_FRAG: begin
                  br[s] <= 17'(brn); bf[s] <= fill;
                end
                crr_pkg::ST_DUP: begin
                  br[s] <= '0; bf[s] <= fill; la[s] <= job.req.piggy_ack;
                end
                crr_pkg::ST_DELIV: begin
                  br[s] <= '0; bf[s] <= fill; la[s] <= job.req.piggy_ack;
                  lr[s] <= job.req.message_id; ls[s] <= lsn;
                  if (job.req.hangup_flag) cv[s] <= 1'b0;
                end
                default: ;
              endcase
            end
          endcase
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hangup_now |-> !out_data.resume_client)
    else $error("resume on hangup");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.deliver |-> out_data.status == crr_pkg::ST_DELIV)
    else $error("deliver without delivered status");
endmodule

// ----- sv/circuit_receive_reassembly.sv -----
// Top level: circuit receive and reassembly engine.
// Each request (open, received header, local send) yields one response;
// mode 3 is dropped silently. A request is held in the front register,
// where the circuit search over the slot table runs, and then passes to
// the back, where the slot update is computed and the response is
// registered. The front reopens once the back has consumed the job,
// since a following header may match the slot being changed. While a
// response waits unaccepted, the next job waits in the front and the
// input stalls. The output register lets a new request enter while a
// response waits. Reset clears the slot valid bits and versions; other
// per-slot fields are set on open.
module circuit_receive_reassembly #(
  parameter int CIRCUITS = crr_pkg::CIRCUITS_DEF,
  parameter int MAX_MESSAGE = crr_pkg::MAX_MESSAGE_DEF
) (
  input logic clk,
  input logic rst,
  crr_if.sink   in,
  crr_if.source out
);
  localparam int IW = (CIRCUITS > 1) ? $clog2(CIRCUITS) : 1;
  logic [CIRCUITS-1:0] cv;
  logic [CIRCUITS-1:0][23:0] rc;
  logic [CIRCUITS-1:0][47:0] pa;
  logic busy, jv, jr;
  crr_pkg::job_t job;

  crr_front #(.CIRCUITS(CIRCUITS), .IW(IW)) u_front (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
    .cv, .rc, .pa, .busy, .job_valid(jv), .job_ready(jr), .job);

  crr_back #(.CIRCUITS(CIRCUITS), .MAX_MESSAGE(MAX_MESSAGE), .IW(IW)) u_back (
    .clk, .rst, .job_valid(jv), .job_ready(jr), .job, .busy, .cv, .rc, .pa,
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data));
endmodule

// ----- tb/circuit_receive_reassembly_tb.sv -----
// Testbench: circuit receive engine checked against a behavioral slot table.
`timescale 1ns / 1ps
module circuit_receive_reassembly_tb;
  localparam int NSLOT = crr_pkg::CIRCUITS_DEF;
  localparam int MAXMSG = crr_pkg::MAX_MESSAGE_DEF;
  localparam int PLMAX = crr_pkg::PAYLOAD_MAX;
  localparam int N_RANDOM = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  crr_if #(.T(crr_pkg::req_t)) in_ch (clk);
  crr_if #(.T(crr_pkg::rsp_t)) out_ch (clk);

  circuit_receive_reassembly u_top (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  // One request waiting to be offered, with the response it must produce.
  typedef struct {
    crr_pkg::req_t req;
    bit   answers;
    crr_pkg::rsp_t rsp;
    bit   drain_first;
  } request_t;

  request_t pending_reqs[$];
  crr_pkg::rsp_t expected_rsps[$];

  int accepted_cnt = 0;
  int mismatches = 0;
  int built_cnt = 0;

  // Shadow of the slot table, advanced as requests are built.
  bit          sh_valid[NSLOT];
  bit   [17:0] sh_version[NSLOT];
  bit   [23:0] sh_circuit[NSLOT];
  bit   [47:0] sh_mac[NSLOT];
  bit          sh_ackw[NSLOT];
  bit   [7:0]  sh_last_rcv[NSLOT];
  bit   [7:0]  sh_cur_msg[NSLOT];
  int          sh_remain[NSLOT];
  int          sh_fill[NSLOT];
  bit   [7:0]  sh_last_sent[NSLOT];
  bit   [7:0]  sh_last_ack[NSLOT];

  // Header handling: match, reassemble, sequence check, ack and hangup.
  function automatic crr_pkg::rsp_t receive_header(input crr_pkg::req_t r);
    crr_pkg::rsp_t o;
    int s;
    int len;
    int rem;
    bit hit;
    o = '0;
    hit = 1'b0;
    len = (r.payload_length > PLMAX) ? PLMAX : int'(r.payload_length);
    rem = int'(r.remaining);
    for (s = 0; s < NSLOT; s++) begin
      if (sh_valid[s] && sh_circuit[s] == r.circuit_number && sh_mac[s] == r.peer_mac) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      // dead reply: swap id and ack
      o.status = crr_pkg::ST_NOCL;
      o.send_ack = 1'b1;
      o.ack_mid = r.piggy_ack;
      o.ack_ack = r.message_id;
      return o;
    end
    o.circuit_slot = s[4:0];
    if (rem >= 0) begin
      sh_fill[s] = 0;
      sh_cur_msg[s] = r.message_id;
      if (rem > MAXMSG) begin
        sh_remain[s] = 0;
        o.status = crr_pkg::ST_OVER;
        return o;
      end
      sh_remain[s] = rem;
    end else if (sh_cur_msg[s] != r.message_id || -rem != sh_remain[s]) begin
      sh_fill[s] = 0;
      o.status = crr_pkg::ST_BAD;
      return o;
    end
    sh_remain[s] -= len;
    if (sh_remain[s] < 0) begin
      if (-sh_remain[s] <= len) begin
        len += sh_remain[s];
        sh_remain[s] = 0;
      end else begin
        o.status = crr_pkg::ST_SHORT;
        return o;
      end
    end
    o.copy_offset = sh_fill[s][13:0];
    o.copy_length = len[10:0];
    sh_fill[s] += len;
    if (sh_remain[s] != 0) begin
      o.status = crr_pkg::ST_FRAG;
      return o;
    end
    if (sh_last_rcv[s] + 8'd1 != sh_cur_msg[s]) begin
      if (sh_last_rcv[s] == sh_cur_msg[s]) begin
        sh_last_ack[s] = r.piggy_ack;
        if (sh_fill[s] != 0) begin
          o.send_ack = 1'b1;
          o.ack_mid = sh_last_sent[s];
          o.ack_ack = sh_last_rcv[s];
        end
        o.resume_client = (sh_last_ack[s] == sh_last_sent[s]);
        o.status = crr_pkg::ST_DUP;
        return o;
      end
      sh_fill[s] = 0;
      o.status = crr_pkg::ST_ORDER;
      return o;
    end
    sh_last_rcv[s] = sh_cur_msg[s];
    sh_last_ack[s] = r.piggy_ack;
    o.status = crr_pkg::ST_DELIV;
    o.resume_client = (sh_last_ack[s] == sh_last_sent[s]);
    if (sh_fill[s] != 0) begin
      o.deliver = 1'b1;
      o.message_length = sh_fill[s][13:0];
    end
    if (r.hangup_flag) begin
      // the hangup packet itself counts as one more message sent
      sh_last_sent[s] = sh_last_sent[s] + 8'd1;
      sh_valid[s] = 1'b0;
      o.resume_client = 1'b0;
      o.hangup_now = 1'b1;
    end
    if (sh_ackw[s]) begin
      o.send_ack = 1'b1;
      o.ack_mid = sh_last_sent[s];
      o.ack_ack = sh_last_rcv[s];
    end
    return o;
  endfunction

  // Advance the shadow table by one request; return 0 where none is answered.
  function automatic bit predict_rsp(input crr_pkg::req_t r, output crr_pkg::rsp_t o);
    int s;
    longint c;
    o = '0;
    s = r.slot;
    if (r.mode == crr_pkg::MODE_RECV) begin
      o = receive_header(r);
      return 1'b1;
    end
    if (r.mode != crr_pkg::MODE_OPEN && r.mode != crr_pkg::MODE_SEND) return 1'b0;
    o.circuit_slot = r.slot;
    if (s >= NSLOT) begin
      o.status = crr_pkg::ST_NOCL;
    end else if (r.mode == crr_pkg::MODE_OPEN) begin
      c = 2 * (longint'(s) + longint'(sh_version[s]) * NSLOT) + 1;
      sh_valid[s] = 1'b1;
      sh_circuit[s] = c[23:0];
      sh_version[s] = sh_version[s] + 18'd1;
      sh_mac[s] = r.peer_mac;
      sh_ackw[s] = r.wants_ack;
      sh_last_rcv[s] = '0;
      sh_cur_msg[s] = '0;
      sh_remain[s] = 0;
      sh_fill[s] = 0;
      sh_last_sent[s] = '0;
      sh_last_ack[s] = '0;
      o.status = crr_pkg::ST_DONE;
    end else if (!sh_valid[s]) begin
      o.status = crr_pkg::ST_NOCL;
    end else begin
      sh_last_sent[s] = sh_last_sent[s] + 8'd1;
      o.status = crr_pkg::ST_DONE;
    end
    return 1'b1;
  endfunction

  // Queue one request together with its predicted response.
  task automatic queue_req(input crr_pkg::req_t r, input bit drain = 1'b0);
    request_t p;
    p.req = r;
    p.drain_first = drain;
    p.answers = predict_rsp(r, p.rsp);
    if (p.answers) built_cnt++;
    pending_reqs.push_back(p);
  endtask

  function automatic bit [47:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic crr_pkg::req_t rand_req();
    logic [127:0] raw;
    crr_pkg::req_t r;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    r = raw[$bits(crr_pkg::req_t)-1:0];
    return r;
  endfunction

  task automatic open_slot(input int s, input bit [47:0] mac, input bit ack);
    crr_pkg::req_t r;
    r = rand_req();
    r.mode = crr_pkg::MODE_OPEN;
    r.slot = s[4:0];
    r.peer_mac = mac;
    r.wants_ack = ack;
    queue_req(r);
  endtask

  task automatic local_send(input int s);
    crr_pkg::req_t r;
    r = rand_req();
    r.mode = crr_pkg::MODE_SEND;
    r.slot = s[4:0];
    queue_req(r);
  endtask

  // Header aimed at the circuit currently held in slot s.
  task automatic header(input int s, input bit hang, input bit [7:0] mid,
                        input bit [7:0] pack, input int rem, input int plen);
    crr_pkg::req_t r;
    r = rand_req();
    r.mode = crr_pkg::MODE_RECV;
    r.circuit_number = sh_circuit[s];
    r.peer_mac = sh_mac[s];
    r.hangup_flag = hang;
    r.message_id = mid;
    r.piggy_ack = pack;
    r.remaining = rem[15:0];
    r.payload_length = plen[10:0];
    queue_req(r);
  endtask

  function automatic int pick_plen();
    int k;
    k = $urandom_range(99);
    if (k < 8) return $urandom_range(PLMAX + 1, 2047);
    if (k < 20) return $urandom_range(600, PLMAX);
    return $urandom_range(1, 400);
  endfunction

  // Send a whole message as start plus continuations; corrupt one now and then.
  task automatic message(input int s, input int len, input bit [7:0] mid,
                         input bit hang, input bit [7:0] pack);
    int guard;
    header(s, hang, mid, pack, len, pick_plen());
    guard = 0;
    while (sh_valid[s] && sh_remain[s] > 0 && sh_cur_msg[s] == mid && guard < 40) begin
      guard++;
      if ($urandom_range(99) < 4) begin
        header(s, hang, mid + 8'($urandom_range(0, 1)), pack,
               -(sh_remain[s] + 1 - $urandom_range(0, 1) * 2), pick_plen());
        break;
      end
      header(s, hang, mid, pack, -sh_remain[s], pick_plen());
    end
  endtask

  task automatic random_message(input int s);
    int len;
    int k;
    bit [7:0] mid;
    bit [7:0] pack;
    k = $urandom_range(99);
    if (k < 3) len = $urandom_range(MAXMSG + 1, 32767);
    else if (k < 6) len = $urandom_range(6000, MAXMSG);
    else if (k < 10) len = 0;
    else len = $urandom_range(1, 2500);
    k = $urandom_range(99);
    if (k < 80) mid = sh_last_rcv[s] + 8'd1;
    else if (k < 90) mid = sh_last_rcv[s];
    else mid = 8'($urandom());
    pack = ($urandom_range(99) < 60) ? sh_last_sent[s] : 8'($urandom());
    message(s, len, mid, $urandom_range(99) < 4, pack);
  endtask

  function automatic int some_open_slot();
    int s;
    int tries;
    for (tries = 0; tries < 64; tries++) begin
      s = $urandom_range(NSLOT - 1);
      if (sh_valid[s]) return s;
    end
    return -1;
  endfunction

  task automatic build_stimulus();
    crr_pkg::req_t r;
    int s;
    int k;
    // directed: table edges, each status but ST_SHORT, mac extremes
    open_slot(0, 48'h0, 1'b1);
    open_slot(NSLOT - 1, 48'hffff_ffff_ffff, 1'b0);
    local_send(5);                         // send on a free slot
    r = rand_req();
    r.mode = crr_pkg::MODE_NONE;           // unknown mode, dropped
    queue_req(r);
    r = rand_req();
    r.mode = crr_pkg::MODE_RECV;
    r.circuit_number = 24'hffffff;         // no matching circuit
    queue_req(r);
    header(0, 1'b0, 8'd1, 8'd0, 100, 100); // single-packet delivery
    header(0, 1'b0, 8'd1, 8'd0, 50, 80);   // duplicate with padding
    header(NSLOT - 1, 1'b0, 8'd1, 8'd0, 3000, 2047); // oversized payload
    header(NSLOT - 1, 1'b0, 8'd1, 8'd0, -1510, 1490);
    header(NSLOT - 1, 1'b0, 8'd1, 8'd0, -20, 10);    // another fragment, message still incomplete
    header(NSLOT - 1, 1'b0, 8'd9, 8'd0, 0, 0);       // out of order, empty
    header(0, 1'b0, 8'd2, 8'd0, MAXMSG + 1, 5);      // overflow
    header(0, 1'b0, 8'd2, 8'd0, -5, 5);              // continuation after overflow
    header(0, 1'b0, 8'd2, 8'd0, 32767, 5);
    header(0, 1'b0, 8'd2, 8'd0, -32768, 0);          // bad count
    local_send(0);
    header(0, 1'b0, 8'd2, 8'd1, MAXMSG, 1490);
    header(0, 1'b1, 8'd2, 8'd1, -(MAXMSG - 1490), 1490);
    header(0, 1'b1, 8'd3, 8'd1, 0, 0);               // out of order, slot still open
    open_slot(NSLOT - 1, 48'h8000_0000_0001, 1'b1);  // reopen a live slot
    header(NSLOT - 1, 1'b1, 8'd1, 8'd0, 0, 0);       // empty message, hangup
    // random part, mostly well-formed traffic on open circuits
    while (built_cnt < N_RANDOM) begin
      k = $urandom_range(99);
      s = some_open_slot();
      if (k < 70 && s >= 0) begin
        random_message(s);
      end else if (k < 80 || s < 0) begin
        open_slot($urandom_range(NSLOT - 1), rand_mac(), 1'($urandom_range(1)));
      end else if (k < 88) begin
        local_send($urandom_range(NSLOT - 1));
      end else if (k < 95) begin
        r = rand_req();
        r.mode = crr_pkg::MODE_RECV;
        if (s >= 0 && $urandom_range(1)) r.circuit_number = sh_circuit[s];
        queue_req(r);
      end else begin
        queue_req(rand_req());
      end
      // once, hold the sender until the engine has answered everything
      if (built_cnt >= 900 && built_cnt < 920) begin
        r = rand_req();
        r.mode = crr_pkg::MODE_SEND;
        queue_req(r, 1'b1);
        built_cnt += 20;
      end
    end
  endtask

  // Driver: offer the oldest pending request, hold it until it is taken.
  always @(posedge clk) begin
    bit offer;
    bit idle;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (pending_reqs[0].answers) expected_rsps.push_back(pending_reqs[0].rsp);
        void'(pending_reqs.pop_front());
        accepted_cnt++;
      end
      idle = ($urandom_range(99) < 17) && !(accepted_cnt > 1100 && accepted_cnt < 1400);
      if (in_ch.valid && !in_ch.ready) begin
        offer = 1'b1;
      end else if (pending_reqs.size() == 0 || idle) begin
        offer = 1'b0;
      end else begin
        offer = !pending_reqs[0].drain_first || expected_rsps.size() == 0;
      end
      in_ch.valid <= offer;
      if (offer) in_ch.data <= pending_reqs[0].req;
    end
  end

  // Monitor: compare each response with the oldest expectation.
  int holdoff = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk) begin
    crr_pkg::rsp_t want;
    crr_pkg::rsp_t got;
    bit bad;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", got);
        end else begin
          want = expected_rsps.pop_front();
          bad = got.circuit_slot !== want.circuit_slot || got.status !== want.status ||
                got.copy_offset !== want.copy_offset ||
                got.copy_length !== want.copy_length || got.deliver !== want.deliver ||
                got.message_length !== want.message_length ||
                got.send_ack !== want.send_ack || got.ack_mid !== want.ack_mid ||
                got.ack_ack !== want.ack_ack || got.resume_client !== want.resume_client ||
                got.hangup_now !== want.hangup_now;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      // long receiver stall once, to back the engine up into its input
      if (!holdoff_done && accepted_cnt >= 500) begin
        holdoff_done = 1'b1;
        holdoff = 400;
      end
      if (holdoff > 0) begin
        holdoff--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(($urandom_range(99) < 17) && !(accepted_cnt > 1100 && accepted_cnt < 1400));
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
